FILE: design/cgbd_pkg.sv
// ----------------------------------------------------------------------------
// cgbd_pkg: shared types and constants for the column gap boundary detector
// Sizes, register map, stage payload and the phase divider state encoding.
// ----------------------------------------------------------------------------
package cgbd_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 1024;

  localparam int CNT_W   = 11;
  localparam int SPAN_W  = 6;
  localparam int THR_W   = 17;
  localparam int STEP_W  = 6;
  localparam int BCOL_W  = 11;
  localparam int OSUM_W  = 17;

  localparam int COL_W   = $clog2(MAX_WIDTH) + 1;
  localparam int PTR_W   = $clog2(MAX_WINDOW);
  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int WSUM_W  = $clog2(MAX_WINDOW * MAX_HEIGHT + 1);
  localparam int SUM_W   = (WSUM_W > THR_W) ? WSUM_W : THR_W;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SPAN = 2'd0;
  localparam reg_idx_t REG_THR  = 2'd1;
  localparam reg_idx_t REG_STEP = 2'd2;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [THR_W-1:0]  thr;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic              last;
    logic              eval;
    logic              base_zero;
    logic [SUM_W-1:0]  psum;
    logic [BCOL_W-1:0] bcol;
  } s1_t;

  typedef enum logic [2:0] {
    PD_IDLE = 3'b001,
    PD_LOAD = 3'b010,
    PD_RUN  = 3'b100
  } pd_state_t;

endpackage

FILE: design/column_gap_boundary_detector_unit.sv
// ----------------------------------------------------------------------------
// column_gap_boundary_detector_unit: top level
// Projection-profile gap detector over per-column dark-pixel counts.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one request per image column, in order,
// carrying the column's dark count and a last-column flag. Output channel
// (out_valid/out_stall): at most one request per column, giving the first
// column of a blank window that follows an inked one, and the sum before it.
// A result passes through the evaluation stage register and then the result register.
// Throughput: one column per cycle unless stalled; the window sum is a difference of two
// prefix sums, one read from a 64-entry ring, so it costs one port per item.
// A write to window_span or scan_step starts a bit-serial remainder over the
// column index; input stalls while that remainder unit is busy.
// Reset: registers return to span 4, threshold 10, step 1, and frame state
// clears; the ring needs no clearing pass. A last column clears frame state.
// When the output stalls with a result held, columns keep entering the
// evaluation stage; input stalls once the column there also produces one.
// APB: span at 0x0, threshold at 0x4, step at 0x8; pready is tied high.
// ----------------------------------------------------------------------------
module column_gap_boundary_detector_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cgbd_pkg::CNT_W-1:0]   in_column_count,
  input  logic                         in_last_column,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cgbd_pkg::BCOL_W-1:0]  out_boundary_column,
  output logic [cgbd_pkg::OSUM_W-1:0]  out_previous_sum,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cgbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [cgbd_pkg::DATA_W-1:0]  pwdata,
  output logic [cgbd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import cgbd_pkg::*;

  cfg_t              cfg;
  logic              recalc;
  logic              pd_busy;
  logic              pd_done;
  logic [STEP_W-1:0] pd_phase;
  logic [COL_W-1:0]  col;
  logic              s1_valid;
  s1_t               s1;
  logic [SUM_W-1:0]  base;
  logic              adv;
  logic              accept;

  assign in_stall = (s1_valid && !adv) || pd_busy;
  assign accept   = in_valid && !in_stall;

  cgbd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .recalc  (recalc)
  );

  cgbd_phase_mod u_phase (
    .clk   (clk),
    .rst_n (rst_n),
    .start (recalc),
    .col   (col),
    .cfg   (cfg),
    .busy  (pd_busy),
    .done  (pd_done),
    .phase (pd_phase)
  );

  cgbd_prefix_line u_prefix (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .count    (in_column_count),
    .last     (in_last_column),
    .cfg      (cfg),
    .ph_load  (pd_done),
    .ph_value (pd_phase),
    .adv      (adv),
    .col      (col),
    .s1_valid (s1_valid),
    .s1       (s1),
    .base     (base)
  );

  cgbd_gap_eval u_eval (
    .clk                 (clk),
    .rst_n               (rst_n),
    .s1_valid            (s1_valid),
    .s1                  (s1),
    .base                (base),
    .cfg                 (cfg),
    .out_stall           (out_stall),
    .adv                 (adv),
    .out_valid           (out_valid),
    .out_boundary_column (out_boundary_column),
    .out_previous_sum    (out_previous_sum)
  );

`ifndef SYNTHESIS
  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid && s1.eval))
    else $error("result without an evaluated column");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_column) |=> (col == '0))
    else $error("column index not cleared after last column");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col <= COL_W'(MAX_WIDTH))
    else $error("column index past frame width");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(recalc) |-> !accept)
    else $error("column accepted during phase recompute");
`endif

endmodule

FILE: design/cgbd_cfg_regs.sv
// ----------------------------------------------------------------------------
// cgbd_cfg_regs: APB register bank
// Holds window span, dark threshold and scan step; flags span/step writes.
// ----------------------------------------------------------------------------
module cgbd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cgbd_pkg::ADDR_W-1:0]  paddr,
  input  logic [cgbd_pkg::DATA_W-1:0]  pwdata,
  output logic [cgbd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output cgbd_pkg::cfg_t               cfg,
  output logic                         recalc
);
  import cgbd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;
  assign recalc = wr_en && ((idx == REG_SPAN) || (idx == REG_STEP));

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SPAN: cfg_nxt.span = pwdata[SPAN_W-1:0];
        REG_THR:  cfg_nxt.thr  = pwdata[THR_W-1:0];
        REG_STEP: cfg_nxt.step = pwdata[STEP_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPAN: prdata = DATA_W'(cfg_r.span);
      REG_THR:  prdata = DATA_W'(cfg_r.thr);
      REG_STEP: prdata = DATA_W'(cfg_r.step);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.span <= SPAN_W'(4);
      cfg_r.thr  <= THR_W'(10);
      cfg_r.step <= STEP_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/cgbd_phase_mod.sv
// ----------------------------------------------------------------------------
// cgbd_phase_mod: bit-serial remainder unit
// Recomputes (column - span) mod step after a span or step write.
// ----------------------------------------------------------------------------
module cgbd_phase_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cgbd_pkg::COL_W-1:0]   col,
  input  cgbd_pkg::cfg_t               cfg,
  output logic                         busy,
  output logic                         done,
  output logic [cgbd_pkg::STEP_W-1:0]  phase
);
  import cgbd_pkg::*;

  localparam int ITER_W = (COL_W > 1) ? $clog2(COL_W) : 1;

  pd_state_t         state_r, state_nxt;
  logic [COL_W-1:0]  dvd_r;
  logic [STEP_W-1:0] rem_r;
  logic [ITER_W-1:0] iter_r;
  logic [STEP_W-1:0] stepe;
  logic [STEP_W:0]   r2;
  logic [STEP_W:0]   rem_nxt;
  logic              last_iter;

  assign stepe     = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
  assign r2        = {rem_r, dvd_r[COL_W-1]};
  assign rem_nxt   = (r2 >= {1'b0, stepe}) ? (r2 - {1'b0, stepe}) : r2;
  assign last_iter = (iter_r == ITER_W'(COL_W - 1));
  assign busy      = (state_r != PD_IDLE);
  assign done      = (state_r == PD_RUN) && last_iter && !start;
  assign phase     = rem_nxt[STEP_W-1:0];

  always_comb begin
    state_nxt = state_r;
    if (start) begin
      state_nxt = PD_LOAD;
    end else begin
      case (state_r)
        PD_IDLE: state_nxt = PD_IDLE;
        PD_LOAD: state_nxt = PD_RUN;
        PD_RUN:  state_nxt = last_iter ? PD_IDLE : PD_RUN;
        default: state_nxt = PD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == PD_LOAD) begin
      dvd_r  <= (col < COL_W'(cfg.span)) ? '0 : (col - COL_W'(cfg.span));
      rem_r  <= '0;
      iter_r <= '0;
    end else if (state_r == PD_RUN) begin
      dvd_r  <= {dvd_r[COL_W-2:0], 1'b0};
      rem_r  <= rem_nxt[STEP_W-1:0];
      iter_r <= iter_r + ITER_W'(1);
    end
  end

endmodule

FILE: design/cgbd_prefix_line.sv
// ----------------------------------------------------------------------------
// cgbd_prefix_line: input stage with prefix-sum ring
// Tracks column, step phase and running prefix sum; fetches the prefix sum
// from one window back and registers the item for evaluation.
// ----------------------------------------------------------------------------
module cgbd_prefix_line (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [cgbd_pkg::CNT_W-1:0]   count,
  input  logic                         last,
  input  cgbd_pkg::cfg_t               cfg,
  input  logic                         ph_load,
  input  logic [cgbd_pkg::STEP_W-1:0]  ph_value,
  input  logic                         adv,
  output logic [cgbd_pkg::COL_W-1:0]   col,
  output logic                         s1_valid,
  output cgbd_pkg::s1_t                s1,
  output logic [cgbd_pkg::SUM_W-1:0]   base
);
  import cgbd_pkg::*;

  logic [SUM_W-1:0]  mem [MAX_WINDOW];
  logic [SUM_W-1:0]  mrd_r;
  logic [COL_W-1:0]  col_r;
  logic [SUM_W-1:0]  psum_r;
  logic [PTR_W-1:0]  wptr_r;
  logic [STEP_W-1:0] ph_r;
  logic              s1_v_r;
  s1_t               s1_r;

  logic              act;
  logic [CNT_W-1:0]  cnt_c;
  logic [SUM_W-1:0]  psum_new;
  logic [STEP_W-1:0] stepe;
  logic [LEN_W-1:0]  len_c;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W-1:0]  wptr_inc;
  logic [STEP_W-1:0] ph_inc;
  logic              past_span;
  int                rp_i;

  assign act       = (col_r < COL_W'(MAX_WIDTH));
  assign cnt_c     = (int'(count) > MAX_HEIGHT) ? CNT_W'(MAX_HEIGHT) : count;
  assign psum_new  = psum_r + SUM_W'(cnt_c);
  assign stepe     = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
  assign len_c     = (int'(cfg.span) + 1 > MAX_WINDOW) ? LEN_W'(MAX_WINDOW)
                                                       : LEN_W'(int'(cfg.span) + 1);
  assign rp_i      = (int'(wptr_r) >= int'(len_c)) ? (int'(wptr_r) - int'(len_c))
                                                   : (int'(wptr_r) + MAX_WINDOW - int'(len_c));
  assign rptr      = PTR_W'(rp_i);
  assign wptr_inc  = (int'(wptr_r) + 1 >= MAX_WINDOW) ? '0 : (wptr_r + PTR_W'(1));
  assign past_span = (col_r >= COL_W'(cfg.span));
  assign ph_inc    = (int'(ph_r) + 1 >= int'(stepe)) ? '0 : (ph_r + STEP_W'(1));

  assign col      = col_r;
  assign s1_valid = s1_v_r;
  assign s1       = s1_r;
  assign base     = mrd_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (act) begin
        mem[wptr_r] <= psum_new;
      end
      mrd_r <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.last      <= last;
      s1_r.eval      <= act && past_span && (ph_r == '0);
      s1_r.base_zero <= (int'(col_r) < int'(len_c));
      s1_r.psum      <= psum_new;
      s1_r.bcol      <= BCOL_W'(col_r - COL_W'(cfg.span));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      psum_r <= '0;
      wptr_r <= '0;
      ph_r   <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (accept && last) begin
        col_r  <= '0;
        psum_r <= '0;
        wptr_r <= '0;
        ph_r   <= '0;
      end else if (accept && act) begin
        col_r  <= col_r + COL_W'(1);
        psum_r <= psum_new;
        wptr_r <= wptr_inc;
        ph_r   <= past_span ? ph_inc : '0;
      end else if (ph_load) begin
        ph_r <= ph_value;
      end
    end
  end

endmodule

FILE: design/cgbd_gap_eval.sv
// ----------------------------------------------------------------------------
// cgbd_gap_eval: window sum check and result register
// Forms the window sum, detects ink-to-gap transitions, holds the result.
// ----------------------------------------------------------------------------
module cgbd_gap_eval (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  cgbd_pkg::s1_t                s1,
  input  logic [cgbd_pkg::SUM_W-1:0]   base,
  input  cgbd_pkg::cfg_t               cfg,
  input  logic                         out_stall,
  output logic                         adv,
  output logic                         out_valid,
  output logic [cgbd_pkg::BCOL_W-1:0]  out_boundary_column,
  output logic [cgbd_pkg::OSUM_W-1:0]  out_previous_sum
);
  import cgbd_pkg::*;

  logic [SUM_W-1:0]  last_eval_r;
  logic              out_v_r;
  logic [BCOL_W-1:0] bcol_r;
  logic [OSUM_W-1:0] osum_r;
  logic [SUM_W-1:0]  win;
  logic              hit;
  logic              retire;
  logic [OSUM_W-1:0] prev_sat;

  assign win      = s1.psum - (s1.base_zero ? '0 : base);
  assign hit      = s1.eval && (last_eval_r > SUM_W'(cfg.thr)) && (win == '0);
  assign adv      = !hit || !out_v_r || !out_stall;
  assign retire   = s1_valid && adv;
  assign prev_sat = (last_eval_r > SUM_W'({OSUM_W{1'b1}})) ? {OSUM_W{1'b1}}
                                                           : last_eval_r[OSUM_W-1:0];

  assign out_valid           = out_v_r;
  assign out_boundary_column = bcol_r;
  assign out_previous_sum    = osum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_eval_r <= '0;
      out_v_r     <= 1'b0;
    end else begin
      if (retire && s1.last) begin
        last_eval_r <= '0;
      end else if (retire && s1.eval) begin
        last_eval_r <= win;
      end
      if (retire && hit) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire && hit) begin
      bcol_r <= s1.bcol;
      osum_r <= prev_sat;
    end
  end

endmodule

FILE: dv/tb_column_gap_boundary_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_column_gap_boundary_detector_unit: self-checking regression
// Sends per-column dark counts, tracks the sliding window, the evaluation
// grid and the boundary rule in a local predictor, and checks every boundary
// request field by field. Registers are set over APB between phases.
// ----------------------------------------------------------------------------
module tb_column_gap_boundary_detector_unit;
  import cgbd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_LIMIT = 4000;
  localparam int N_DIR = 18;
  localparam int N_PHASE = 10;
  localparam int PHASE_COLUMNS = 80;

  localparam int DIR_COUNTS [N_DIR] = '{1024, 2047, 1025, 0, 0, 0, 0, 0, 0, 3,
                                        7, 0, 0, 0, 0, 0, 1, 0};
  localparam bit DIR_LAST [N_DIR] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                                      0, 0, 0, 0, 0, 0, 0, 1};

  localparam int PH_SPAN [N_PHASE] = '{4, 0, 63, 63, 7, 2, 1, 10, 31, 3};
  localparam int PH_THR [N_PHASE]  = '{10, 0, 0, 65536, 100, 131071, 5, 50, 1000, 1};
  localparam int PH_STEP [N_PHASE] = '{1, 1, 1, 63, 3, 1, 0, 2, 7, 4};

  typedef struct {
    logic [BCOL_W-1:0] col;
    logic [OSUM_W-1:0] psum;
  } boundary_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CNT_W-1:0]  in_column_count = '0;
  logic              in_last_column = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BCOL_W-1:0] out_boundary_column;
  logic [OSUM_W-1:0] out_previous_sum;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  column_gap_boundary_detector_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_column_count     (in_column_count),
    .in_last_column      (in_last_column),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_boundary_column (out_boundary_column),
    .out_previous_sum    (out_previous_sum),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // predictor state
  logic [SPAN_W-1:0] span_cfg;
  logic [THR_W-1:0]  thr_cfg;
  logic [STEP_W-1:0] step_cfg;
  logic [CNT_W-1:0]  col_ring [MAX_WINDOW];
  logic [PTR_W-1:0]  ring_wr;
  logic [SUM_W-1:0]  prev_sum;
  logic [COL_W-1:0]  col_idx;

  boundary_t pending_boundaries [$];

  int fail_count = 0;
  int columns_sent = 0;
  int boundaries_seen = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit src_gaps_en = 1'b0;
  bit sink_backpressure = 1'b0;
  int sink_run = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("column_gap_boundary_detector_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || !sink_backpressure) begin
      out_stall <= 1'b0;
      sink_run <= 0;
    end else if (sink_run != 0) begin
      sink_run <= sink_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 40);
      sink_run <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin : boundary_monitor
    boundary_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_boundaries.size() == 0) begin
        $error("unexpected boundary request: column %0d sum %0d",
               out_boundary_column, out_previous_sum);
        fail_count++;
      end else begin
        want = pending_boundaries.pop_front();
        boundaries_seen++;
        if (out_boundary_column !== want.col) begin
          $error("boundary_column: expected %0d, got %0d", want.col, out_boundary_column);
          fail_count++;
        end
        if (out_previous_sum !== want.psum) begin
          $error("previous_sum: expected %0d, got %0d", want.psum, out_previous_sum);
          fail_count++;
        end
      end
    end
  end

  function automatic void clear_frame_state();
    for (int i = 0; i < MAX_WINDOW; i++) col_ring[i] = '0;
    ring_wr = '0;
    prev_sum = '0;
    col_idx = '0;
  endfunction

  function automatic void model_gap_column(input logic [CNT_W-1:0] raw, input logic lst);
    logic [CNT_W-1:0]  cnt;
    logic [STEP_W-1:0] stp;
    logic [LEN_W-1:0]  wlen;
    logic [PTR_W-1:0]  p;
    logic [COL_W-1:0]  off;
    logic [SUM_W-1:0]  wsum;
    boundary_t         b;
    cnt = (raw > MAX_HEIGHT) ? CNT_W'(MAX_HEIGHT) : raw;
    if (col_idx < MAX_WIDTH) begin
      stp = (step_cfg == 0) ? STEP_W'(1) : step_cfg;
      wlen = LEN_W'(span_cfg) + 1'b1;
      col_ring[ring_wr] = cnt;
      ring_wr = ring_wr + 1'b1;
      if (col_idx >= span_cfg) begin
        off = col_idx - span_cfg;
        if (off % stp == 0) begin
          wsum = '0;
          p = ring_wr;
          for (int i = 0; i < wlen; i++) begin
            p = p - 1'b1;
            wsum += col_ring[p];
          end
          if (prev_sum > thr_cfg && wsum == 0) begin
            b.col = off[BCOL_W-1:0];
            b.psum = prev_sum[OSUM_W-1:0];
            pending_boundaries.insert(pending_boundaries.size(), b);
          end
          prev_sum = wsum;
        end
      end
      col_idx++;
    end
    if (lst) clear_frame_state();
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_SPAN: return DATA_W'(span_cfg);
      REG_THR:  return DATA_W'(thr_cfg);
      REG_STEP: return DATA_W'(step_cfg);
      default:  return '0;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] ink_count();
    case ($urandom_range(0, 19))
      0:             return CNT_W'($urandom_range(MAX_HEIGHT + 1, 2047));
      1:             return CNT_W'(MAX_HEIGHT);
      2:             return '0;
      3, 4, 5, 6:    return CNT_W'($urandom_range(1, 8));
      default:       return CNT_W'($urandom_range(1, MAX_HEIGHT));
    endcase
  endfunction

  task automatic push_column(input logic [CNT_W-1:0] cnt, input logic lst);
    int gap;
    if (src_gaps_en && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_column_count <= cnt;
    in_last_column <= lst;
    do @(posedge clk); while (in_stall);
    model_gap_column(cnt, lst);
    columns_sent++;
  endtask

  task automatic settle_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_boundaries.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_boundaries.size() != 0) begin
      $error("boundary requests never arrived: %0d outstanding", pending_boundaries.size());
      fail_count++;
      pending_boundaries.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_read_check(input reg_idx_t idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, reg_value(idx), prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SPAN: span_cfg = value[SPAN_W-1:0];
      REG_THR:  thr_cfg = value[THR_W-1:0];
      REG_STEP: step_cfg = value[STEP_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_read_check(idx);
  endtask

  task automatic set_config(input int span, input int thr, input int step);
    cfg_write(REG_SPAN, DATA_W'(span));
    cfg_write(REG_THR, DATA_W'(thr));
    cfg_write(REG_STEP, DATA_W'(step));
  endtask

  // ink runs alternate with blank runs sized around the window
  task automatic shaped_frame(input int n, input bit close);
    int  run;
    bit  inking;
    inking = 1'b1;
    run = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if (run == 0) begin
        inking = !inking;
        run = inking ? $urandom_range(1, 6) : $urandom_range(span_cfg / 2 + 1, span_cfg + 4);
      end
      push_column(inking ? ink_count() : CNT_W'(0), close && (k == n - 1));
      run--;
    end
  endtask

  task automatic noise_columns(input int n);
    logic [CNT_W-1:0] c;
    for (int k = 0; k < n; k++) begin
      c = ($urandom_range(0, 2) == 0) ? CNT_W'(0) : CNT_W'($urandom_range(0, 2047));
      push_column(c, $urandom_range(0, 39) == 0);
    end
  endtask

  task automatic test_register_defaults();
    cfg_read_check(REG_SPAN);
    cfg_read_check(REG_THR);
    cfg_read_check(REG_STEP);
  endtask

  // clamped counts, a boundary, a mid-frame last, a sum under threshold
  task automatic test_directed_columns();
    src_gaps_en = 1'b0;
    sink_backpressure = 1'b0;
    for (int i = 0; i < N_DIR; i++) push_column(CNT_W'(DIR_COUNTS[i]), DIR_LAST[i]);
    settle_idle();
    set_config(0, 0, 0);
    for (int i = 0; i < N_DIR; i++) push_column(CNT_W'(DIR_COUNTS[i]), DIR_LAST[i]);
    settle_idle();
  endtask

  task automatic test_mid_frame_update();
    src_gaps_en = 1'b1;
    sink_backpressure = 1'b1;
    set_config(4, 10, 1);
    shaped_frame(13, 1'b0);
    settle_idle();
    set_config(2, 3, 3);
    shaped_frame(20, 1'b0);
    settle_idle();
    cfg_write(REG_SPAN, DATA_W'(6));
    shaped_frame(25, 1'b1);
    settle_idle();
  endtask

  task automatic run_phase(input int span, input int thr, input int step, input int idx);
    int start;
    int len;
    src_gaps_en = (idx % 3 != 0);
    sink_backpressure = (idx % 4 != 1);
    set_config(span, thr, step);
    start = columns_sent;
    while (columns_sent - start < PHASE_COLUMNS) begin
      len = $urandom_range(span_cfg + 2, 3 * span_cfg + 30);
      if ($urandom_range(0, 99) < 85) shaped_frame(len, 1'b1);
      else noise_columns(len);
    end
    settle_idle();
  endtask

  task automatic test_random_frames();
    for (int i = 0; i < N_PHASE; i++) run_phase(PH_SPAN[i], PH_THR[i], PH_STEP[i], i);
  endtask

  initial begin
    span_cfg = SPAN_W'(4);
    thr_cfg = THR_W'(10);
    step_cfg = STEP_W'(1);
    clear_frame_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_directed_columns();
    test_mid_frame_update();
    test_random_frames();
    settle_idle();
    $display("covered %0d columns, %0d boundary requests, %0d register writes",
             columns_sent, boundaries_seen, reg_writes);
    if (fail_count == 0) begin
      $display("column_gap_boundary_detector_unit regression: pass");
    end else begin
      $display("column_gap_boundary_detector_unit regression: fail");
    end
    $finish;
  end

endmodule
